[hw/rtl/allele_set_distance_min_search_core_macros.svh]
// Assertion macros for the allele set distance search core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ALLELE_SET_DISTANCE_MIN_SEARCH_CORE_MACROS_SVH
`define ALLELE_SET_DISTANCE_MIN_SEARCH_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Check a property at every rising clock edge outside reset.
`define ASDMS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check that a condition implies a result in the next cycle.
`define ASDMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASDMS_ASSERT(lbl, clk, rst_n, prop)
`define ASDMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/asdms_pkg.sv]
// Shared types and constants for the allele set distance search core.
// No dependencies.
package asdms_pkg;

  // Branch count bound; the branch index saturates one below it.
  localparam int unsigned MaxBranches = 65536;

  localparam logic [15:0] DistLimit = 16'hFFFE;
  localparam logic [15:0] BestReset = 16'hFFFF;
  localparam logic [15:0] CntLimit  =
      (MaxBranches - 1 > 32'hFFFF) ? 16'hFFFF : 16'(MaxBranches - 1);
  localparam logic [3:0]  NibbleMask = 4'hF;

  typedef struct packed {
    logic [7:0] leaf_code;
    logic [7:0] branch_alleles;
    logic       last_position;
    logic       last_branch;
  } in_item_t;

  typedef struct packed {
    logic [15:0] branch_distance;
    logic [15:0] branch_number;
    logic [15:0] best_distance;
    logic [15:0] best_number;
    logic        search_done;
  } out_item_t;

endpackage

[hw/rtl/asdms_branch_acc.sv]
// Distance accumulator and running minimum for one search.
// Depends on asdms_pkg and the core macro header.
`include "allele_set_distance_min_search_core_macros.svh"

module asdms_branch_acc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  asdms_pkg::in_item_t  item_i,
  output logic                 res_valid_o,
  output asdms_pkg::out_item_t res_o
);
  import asdms_pkg::*;

  logic [15:0] dist_q, dist_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] best_q, best_d;
  logic [15:0] idx_q, idx_d;

  logic [3:0]  first_allele, second_allele;
  logic        mismatch;
  logic [15:0] dist_new, best_new, idx_new;

  // Count a mismatch when the leaf is known and matches neither allele
  always_comb begin
    first_allele  = item_i.branch_alleles[3:0] & NibbleMask;
    second_allele = item_i.branch_alleles[7:4] & NibbleMask;
    mismatch = (item_i.leaf_code != 8'd0) &&
               (item_i.leaf_code != {4'd0, first_allele}) &&
               (item_i.leaf_code != {4'd0, second_allele});
    dist_new = (mismatch && (dist_q < DistLimit)) ? dist_q + 16'd1 : dist_q;
    if (dist_new < best_q) begin
      best_new = dist_new;
      idx_new  = cnt_q;
    end else begin
      best_new = best_q;
      idx_new  = idx_q;
    end
  end

  // Form the branch result
  always_comb begin
    res_valid_o           = item_i.last_position;
    res_o.branch_distance = dist_new;
    res_o.branch_number   = cnt_q;
    res_o.best_distance   = best_new;
    res_o.best_number     = idx_new;
    res_o.search_done     = item_i.last_branch;
  end

  // Advance state on each request; restart after the last branch
  always_comb begin
    dist_d = dist_q;
    cnt_d  = cnt_q;
    best_d = best_q;
    idx_d  = idx_q;
    if (step_i) begin
      if (!item_i.last_position) begin
        dist_d = dist_new;
      end else if (item_i.last_branch) begin
        dist_d = 16'd0;
        cnt_d  = 16'd0;
        best_d = BestReset;
        idx_d  = 16'd0;
      end else begin
        dist_d = 16'd0;
        if (cnt_q < CntLimit) begin
          cnt_d = cnt_q + 16'd1;
        end
        best_d = best_new;
        idx_d  = idx_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= 16'd0;
      cnt_q  <= 16'd0;
      best_q <= BestReset;
      idx_q  <= 16'd0;
    end else begin
      dist_q <= dist_d;
      cnt_q  <= cnt_d;
      best_q <= best_d;
      idx_q  <= idx_d;
    end
  end

  `ASDMS_ASSERT(a_dist_sat, clk_i, rst_ni, dist_q <= DistLimit)
  `ASDMS_ASSERT(a_cnt_sat, clk_i, rst_ni, cnt_q <= CntLimit)
  `ASDMS_ASSERT(a_best_le_dist, clk_i, rst_ni,
                !step_i || (res_o.best_distance <= res_o.branch_distance))
  `ASDMS_ASSERT_NEXT(a_restart, clk_i, rst_ni,
                     step_i && item_i.last_position && item_i.last_branch,
                     dist_q == 16'd0 && cnt_q == 16'd0 && best_q == BestReset)
  `ASDMS_ASSERT_NEXT(a_best_set, clk_i, rst_ni,
                     step_i && item_i.last_position && !item_i.last_branch,
                     best_q <= DistLimit)

endmodule

[hw/rtl/allele_set_distance_min_search_core.sv]
// Top level of the allele set distance search core: input and result registers.
// Depends on asdms_pkg, asdms_branch_acc and the core macro header.
//
// Takes one genome position per cycle unless stalled, and gives one result at the
// last position of each branch: the position sits in the input register while the
// mismatch count, saturating add and minimum compare run combinationally into the
// result register. While a result waits under a stall the accumulator holds, the
// input register takes at most one more request and the input then stalls.
// Positions other than a branch's last update the state and give no result. The
// state restarts after the result that closes a search.
`include "allele_set_distance_min_search_core_macros.svh"

module allele_set_distance_min_search_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  asdms_pkg::in_item_t  in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output asdms_pkg::out_item_t out_res_o
);
  import asdms_pkg::*;

  logic      in_vld_q;
  in_item_t  in_q;
  logic      out_vld_q;
  out_item_t out_q;

  logic      advance;
  logic      step;
  logic      res_valid;
  out_item_t res;

  // Move on when the result register is empty or being drained
  assign advance    = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;

  asdms_branch_acc u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Hold the input request until the accumulator takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_req_i;
    end
  end

  // Capture a result; hold it while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

  `ASDMS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_vld_q && out_stall_i,
                     out_vld_q && $stable(out_q))
  `ASDMS_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_stall_o,
                     in_vld_q && $stable(in_q))
  `ASDMS_ASSERT(a_stall_cause, clk_i, rst_ni, !in_stall_o || (out_vld_q && out_stall_i))

endmodule

[dv/allele_set_distance_min_search_core_tb.sv]
// Testbench for the allele set distance search core: drives genome positions, scores them
// against a local branch-distance tracker and compares every branch result field by field.
// Depends on asdms_pkg and the allele_set_distance_min_search_core RTL.
`timescale 1ns / 100ps

module allele_set_distance_min_search_core_tb;
  import asdms_pkg::*;

  // One directed request, with its result typed in where it is obvious
  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } step_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_req_i    = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_res_o;

  // Branch-distance tracker state
  logic [15:0] pos_mismatches = 16'd0;
  logic [15:0] branch_idx     = 16'd0;
  logic [15:0] best_dist      = BestReset;
  logic [15:0] best_idx       = 16'd0;

  out_item_t pending_branch_results[$];
  step_row_t directed_rows[$];

  // Traffic shaping shared between the request and result sides
  bit tx_quiet  = 1'b0;
  bit rx_quiet  = 1'b0;
  bit hold_ask  = 1'b0;
  int hold_left = 0;

  int mismatch_count  = 0;
  int positions_sent  = 0;
  int results_seen    = 0;
  int searches_closed = 0;

  allele_set_distance_min_search_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Guard against a hung handshake
  initial begin
    #30000000;
    $display("simulation failed");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // Score one position; return 1 and fill res when it closes a branch
  function automatic bit score_position(input in_item_t req, output out_item_t res);
    logic [15:0] acc_dist;
    acc_dist = pos_mismatches;
    res  = '0;
    if (req.leaf_code != 8'h00 && req.leaf_code != {4'h0, req.branch_alleles[3:0]} &&
        req.leaf_code != {4'h0, req.branch_alleles[7:4]} && acc_dist < DistLimit)
      acc_dist = acc_dist + 16'd1;
    if (!req.last_position) begin
      pos_mismatches = acc_dist;
      return 1'b0;
    end
    // Replace the best only on a strictly smaller distance
    if (acc_dist < best_dist) begin
      best_dist = acc_dist;
      best_idx  = branch_idx;
    end
    res.branch_distance = acc_dist;
    res.branch_number   = branch_idx;
    res.best_distance   = best_dist;
    res.best_number     = best_idx;
    res.search_done     = req.last_branch;
    if (req.last_branch) begin
      pos_mismatches = 16'd0;
      branch_idx     = 16'd0;
      best_dist      = BestReset;
      best_idx       = 16'd0;
    end else begin
      pos_mismatches = 16'd0;
      if (branch_idx < CntLimit) branch_idx = branch_idx + 16'd1;
    end
    return 1'b1;
  endfunction

  // Offer one request, idling first at random, and hold it until accepted
  task automatic offer_position(input in_item_t req, input logic typed, input out_item_t want);
    out_item_t res;
    @(negedge clk_i);
    while (!tx_quiet && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    positions_sent++;
    if (score_position(req, res)) begin
      if (typed) res = want;
      pending_branch_results = {pending_branch_results, res};
    end
  endtask

  // Stop offering and wait for every outstanding branch result
  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_branch_results.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic in_item_t draw_position();
    in_item_t req;
    int unsigned pick;
    req = '0;
    req.branch_alleles = 8'($urandom_range(255));
    pick = $urandom_range(9);
    if (pick < 2)
      req.leaf_code = 8'h00;
    else if (pick < 6)
      req.leaf_code = $urandom_range(1) ? {4'h0, req.branch_alleles[7:4]}
                                        : {4'h0, req.branch_alleles[3:0]};
    else if (pick < 9)
      req.leaf_code = 8'($urandom_range(1, 15));
    else
      req.leaf_code = 8'($urandom_range(255));
    req.last_branch = 1'($urandom_range(1));
    return req;
  endfunction

  function automatic step_row_t mk_row(logic [7:0] leaf, logic [7:0] alleles, int lp,
                                       int lb, int typed, int br_dist,
                                       int num, int bdist,
                                       int bnum, int done);
    step_row_t r;
    r.req   = '{leaf_code: leaf, branch_alleles: alleles, last_position: 1'(lp),
                last_branch: 1'(lb)};
    r.typed = 1'(typed);
    r.want  = '{branch_distance: 16'(br_dist), branch_number: 16'(num),
                best_distance: 16'(bdist), best_number: 16'(bnum), search_done: 1'(done)};
    return r;
  endfunction

  // Append one directed row to the table
  function automatic void add_row(input step_row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  // Compare each accepted result with the oldest outstanding one
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (out_res_o.search_done) searches_closed++;
      if (pending_branch_results.size() == 0) begin
        note_mismatch("unexpected result", out_res_o.branch_number, 16'h0);
      end else begin
        want = pending_branch_results.pop_front();
        if (out_res_o.branch_distance !== want.branch_distance)
          note_mismatch("branch_distance", out_res_o.branch_distance, want.branch_distance);
        if (out_res_o.branch_number !== want.branch_number)
          note_mismatch("branch_number", out_res_o.branch_number, want.branch_number);
        if (out_res_o.best_distance !== want.best_distance)
          note_mismatch("best_distance", out_res_o.best_distance, want.best_distance);
        if (out_res_o.best_number !== want.best_number)
          note_mismatch("best_number", out_res_o.best_number, want.best_number);
        if (out_res_o.search_done !== want.search_done)
          note_mismatch("search_done", 16'(out_res_o.search_done), 16'(want.search_done));
      end
    end
  end

  // Result side: random stalls, plus a counted hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = 64;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !rx_quiet && ($urandom_range(99) < 24);
      end
    end
  end

  initial begin
    in_item_t  req;
    out_item_t none;
    int        random_goal;
    int        search_no;
    int        n_branches;
    int        len;
    none = '0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Missing leaf, wide leaf codes, ignored last branch, ties, restarts
    add_row(mk_row(8'h00, 8'h00, 1, 0, 1, 0, 0, 0, 0, 0));
    add_row(mk_row(8'hFF, 8'hFF, 1, 0, 1, 1, 1, 0, 0, 0));
    add_row(mk_row(8'h05, 8'h05, 0, 1, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(8'h05, 8'h50, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(8'h03, 8'h12, 1, 0, 1, 1, 2, 0, 0, 0));
    add_row(mk_row(8'h01, 8'h00, 1, 1, 1, 1, 3, 0, 0, 1));
    add_row(mk_row(8'h07, 8'h22, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(8'h07, 8'h33, 1, 0, 1, 2, 0, 2, 0, 0));
    add_row(mk_row(8'h09, 8'h00, 1, 0, 1, 1, 1, 1, 1, 0));
    add_row(mk_row(8'h10, 8'h00, 1, 0, 1, 1, 2, 1, 1, 0));
    add_row(mk_row(8'h04, 8'h40, 1, 1, 1, 0, 3, 0, 3, 1));
    add_row(mk_row(8'h80, 8'hF0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(8'h0F, 8'hF0, 0, 1, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(8'h0F, 8'h0F, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(8'hAA, 8'h55, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(8'h0A, 8'hA5, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(8'h01, 8'hEE, 1, 1, 0, 0, 0, 0, 0, 0));
    foreach (directed_rows[i])
      offer_position(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    // Random searches of random branches; some at full rate, one long hold-off
    random_goal = positions_sent + 650;
    search_no   = 0;
    while (positions_sent < random_goal) begin
      search_no++;
      tx_quiet = (search_no % 7 == 3) || (search_no == 4);
      rx_quiet = (search_no % 7 == 3);
      if (search_no == 4) hold_ask = 1'b1;
      if (search_no == 9) pause_until_drained();
      n_branches = $urandom_range(1, 8);
      for (int b = 0; b < n_branches; b++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 6);
        for (int p = 0; p < len; p++) begin
          req = draw_position();
          req.last_position = (p == len - 1);
          if (req.last_position) req.last_branch = (b == n_branches - 1);
          offer_position(req, 1'b0, none);
        end
      end
    end

    // Drain and let the pipeline settle
    pause_until_drained();
    repeat (8) @(negedge clk_i);
    if (pending_branch_results.size() != 0)
      note_mismatch("missing results", 16'(pending_branch_results.size()), 16'h0);

    $display("Sent %0d positions; checked %0d branch results over %0d searches,",
             positions_sent, results_seen, searches_closed);
    $display("covering missing and wide leaf codes, ties, a long result hold-off and a drain.");
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
